// ----- sv/ptct_pkg.sv -----
`default_nettype none
package ptct_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int MAX_OUT   = 8;
    localparam int TICK_W    = 32;
    localparam int HANDLE_W  = 16;
    localparam int STAMP_W   = 30;
    localparam int RAM_W     = HANDLE_W + 2 * TICK_W;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] KIND_FIRED = 2'd0;
    localparam logic [1:0] KIND_ADDED = 2'd1;
    localparam logic [1:0] KIND_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [TICK_W-1:0]   tick_value;
        logic [HANDLE_W-1:0] callback_handle;
        logic [TICK_W-1:0]   phase;
        logic [TICK_W-1:0]   period;
        logic signed [15:0]  slot_tag;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]          kind;
        logic [2:0]          slot_index;
        logic [HANDLE_W-1:0] handle_out;
        logic [STAMP_W-1:0]  tick_stamp;
        logic                last;
    } t_out_beat;

    typedef struct packed {
        logic              done;
        logic [TICK_W-1:0] rem;
    } t_rem_stat;

endpackage
`default_nettype wire

// ----- sv/ptct_ram.sv -----
`default_nettype none
module ptct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                     i_wr_data,
    input  wire logic                                 i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/ptct_rem.sv -----
`default_nettype none
module ptct_rem (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ptct_pkg::TICK_W-1:0] i_dividend,
    input  wire logic [ptct_pkg::TICK_W-1:0] i_divisor,
    output ptct_pkg::t_rem_stat            o_stat
);
    import ptct_pkg::*;

    localparam int CNT_W = $clog2(TICK_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [TICK_W-1:0] r_sh;
    logic [TICK_W-1:0] r_rem;

    logic [TICK_W:0]   w_trial;
    logic [TICK_W:0]   w_diff;
    logic              w_ge;
    logic [TICK_W-1:0] w_next;

    // one dividend bit per cycle, restoring step
    assign w_trial = {r_rem, r_sh[TICK_W-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign w_next  = w_ge ? w_diff[TICK_W-1:0] : w_trial[TICK_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(TICK_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_sh  <= {r_sh[TICK_W-2:0], 1'b0};
            r_rem <= w_next;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.rem  = r_rem;

endmodule
`default_nettype wire

// ----- sv/periodic_tick_callback_table_top.sv -----
// channel | direction | handshake              | beat
// in      | input     | i_in_valid / o_in_stall  | i_in_beat  (t_in_beat)
// out     | output    | o_out_valid / i_out_stall | o_out_beat (t_out_beat)
//
// tick: per slot, a ram read, a start state, the bit-serial remainder unit
//   (one tick bit per cycle) and a check; the walk ends early after MAX_OUT
//   firings, and a flush state sends the last beat if any slot fired
// add: one slot-used bit checked per cycle, then an added or full result beat
// remove and clear: handled in the idle state, no result beat
// reset is synchronous and active low; every slot is free after it
// a stalled output holds the walk at the next firing; the input is stalled
//   while a tick or add item is in work
`default_nettype none
module periodic_tick_callback_table_top #(
    parameter int SLOTS = ptct_pkg::SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire ptct_pkg::t_in_beat i_in_beat,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ptct_pkg::t_out_beat     o_out_beat
);
    import ptct_pkg::*;

    localparam int IDX_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_OUT + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [SLOTS-1:0] r_used, n_used;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_pend_valid, n_pend_valid;
    logic             r_out_valid, n_out_valid;
    t_in_beat         r_item, n_item;
    t_out_beat        r_pend, n_pend;
    t_out_beat        r_out, n_out;

    logic              w_rd_en;
    logic              w_wr_en;
    logic              w_start;
    logic [RAM_W-1:0]  w_wr_data;
    logic [RAM_W-1:0]  w_rd_data;
    logic [HANDLE_W-1:0] w_handle;
    logic [TICK_W-1:0] w_phase;
    logic [TICK_W-1:0] w_period;
    t_rem_stat         w_rem;
    logic              w_fire;
    logic              w_out_free;
    logic              w_idx_last;
    logic              w_tag_ok;
    logic [IDX_W-1:0]  w_tag_idx;

    assign w_wr_data = {r_item.callback_handle, r_item.phase, r_item.period};
    assign {w_handle, w_phase, w_period} = w_rd_data;

    ptct_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    ptct_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_item.tick_value),
        .i_divisor  (w_period),
        .o_stat     (w_rem)
    );

    assign w_fire     = r_used[r_idx] && (w_period != '0) && (w_rem.rem == w_phase);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_idx_last = r_idx == IDX_W'(SLOTS - 1);
    assign w_tag_ok   = !i_in_beat.slot_tag[15]
                        && ({1'b0, i_in_beat.slot_tag[14:0]} < 16'(SLOTS));
    assign w_tag_idx  = i_in_beat.slot_tag[IDX_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_item       = r_item;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        w_rd_en      = 1'b0;
        w_wr_en      = 1'b0;
        w_start      = 1'b0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item       = i_in_beat;
                    n_idx        = '0;
                    n_cnt        = '0;
                    n_pend_valid = 1'b0;
                    unique case (i_in_beat.opcode)
                        OP_TICK: n_state = S_READ;
                        OP_ADD: n_state = S_FIND;
                        OP_REMOVE: begin
                            if (w_tag_ok) begin
                                n_used[w_tag_idx] = 1'b0;
                            end
                        end
                        OP_CLEAR: n_used = '0;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_FIND: begin
                if (!r_used[r_idx]) begin
                    w_wr_en       = 1'b1;
                    n_used[r_idx] = 1'b1;
                    n_pend        = '{kind: KIND_ADDED, slot_index: 3'(r_idx),
                                      handle_out: '0, tick_stamp: '0, last: 1'b1};
                    n_pend_valid  = 1'b1;
                    n_state       = S_FLUSH;
                end else if (w_idx_last) begin
                    n_pend       = '{kind: KIND_FULL, slot_index: '0,
                                     handle_out: '0, tick_stamp: '0, last: 1'b1};
                    n_pend_valid = 1'b1;
                    n_state      = S_FLUSH;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_READ: begin
                w_rd_en = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                w_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_rem.done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!(w_fire && r_pend_valid && !w_out_free)) begin
                    // previous firing goes out once a later one is known
                    if (w_fire) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = r_pend;
                        end
                        n_pend       = '{kind: KIND_FIRED, slot_index: 3'(r_idx),
                                         handle_out: w_handle,
                                         tick_stamp: r_item.tick_value[STAMP_W-1:0],
                                         last: 1'b0};
                        n_pend_valid = 1'b1;
                        n_cnt        = r_cnt + CNT_W'(1);
                    end
                    if (w_fire && r_cnt == CNT_W'(MAX_OUT - 1)) begin
                        n_state = S_FLUSH;
                    end else if (w_idx_last) begin
                        n_state = (w_fire || r_pend_valid) ? S_FLUSH : S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_pend;
                    n_out.last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_idx        <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_idx        <= n_idx;
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule
`default_nettype wire

// ----- sv/ptct_checker.sv -----
`default_nettype none
module ptct_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire ptct_pkg::t_in_beat  i_in_beat,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire ptct_pkg::t_out_beat o_out_beat
);
    import ptct_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("stalled output beat changed");

    a_add_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.kind != KIND_FIRED |->
            o_out_beat.last && o_out_beat.handle_out == '0
            && o_out_beat.tick_stamp == '0)
        else $error("add result beat malformed");

    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.kind == KIND_FULL |-> o_out_beat.slot_index == '0)
        else $error("full result carries a slot");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall
            && (i_in_beat.opcode == OP_TICK || i_in_beat.opcode == OP_ADD)
        |=> o_in_stall)
        else $error("input taken again while an item is in work");

endmodule

bind periodic_tick_callback_table_top ptct_checker u_ptct_checker (.*);
`default_nettype wire
